// ===== hw/rtl/nlej_pkg.sv =====
// ----------------------------------------------------------------------------
// nlej_pkg: shared definitions for the nested-loop equi-join
// Widths, operation codes, sequencer states and the cell control group.
// ----------------------------------------------------------------------------
package nlej_pkg;

   localparam int LEFT_ROWS     = 64;
   localparam int IDX_W         = (LEFT_ROWS > 1) ? $clog2(LEFT_ROWS) : 1;
   localparam int COUNT_W       = $clog2(LEFT_ROWS + 1);
   localparam int OP_W          = 2;
   localparam int KEY_W         = 32;
   localparam int LEFT_INDEX_W  = 6;
   localparam int RIGHT_INDEX_W = 16;
   localparam int RSP_FIELDS_W  = LEFT_INDEX_W + RIGHT_INDEX_W + KEY_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [IDX_W-1:0]         LAST_STEP = IDX_W'(LEFT_ROWS - 1);
   localparam logic [COUNT_W-1:0]       FULL_COUNT = COUNT_W'(LEFT_ROWS);
   localparam logic [RIGHT_INDEX_W-1:0] RIGHT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_PROBE = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             shift;
      logic             load;
      logic [IDX_W-1:0] load_sel;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/nlej_cell.sv =====
// ----------------------------------------------------------------------------
// nlej_cell: one left-key cell of the rotating key ring
// Holds one stored key; takes a new key on load or its neighbor's on shift.
// ----------------------------------------------------------------------------
module nlej_cell (
   input  logic                      clock,
   input  logic                      load_en,
   input  logic                      shift_en,
   input  logic [nlej_pkg::KEY_W-1:0] load_key,
   input  logic [nlej_pkg::KEY_W-1:0] neighbor_key,
   output logic [nlej_pkg::KEY_W-1:0] cell_key
);

   logic [nlej_pkg::KEY_W-1:0] key_ff;
   logic [nlej_pkg::KEY_W-1:0] key_in;

   always_comb begin
      key_in = key_ff;
      priority if (load_en) begin
         key_in = load_key;
      end else if (shift_en) begin
         key_in = neighbor_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign cell_key = key_ff;

endmodule

// ===== hw/rtl/nlej_ctrl.sv =====
// ----------------------------------------------------------------------------
// nlej_ctrl: probe sequencer and result register
// Counts rows, rotates the key ring past the head comparator, holds one
// match back to mark the final one, and drives the result channel.
// ----------------------------------------------------------------------------
module nlej_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nlej_pkg::KEY_W-1:0]        req_tdata,
   input  logic [nlej_pkg::OP_W-1:0]         req_tuser,
   input  logic [nlej_pkg::KEY_W-1:0]        head_key,
   output nlej_pkg::cell_ctl_type            cell_ctl,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nlej_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   nlej_pkg::state_type                     state_ff, state_in;
   logic [nlej_pkg::COUNT_W-1:0]            count_ff, count_in;
   logic [nlej_pkg::RIGHT_INDEX_W-1:0]      right_ff, right_in;
   logic [nlej_pkg::IDX_W-1:0]              step_ff, step_in;
   logic [nlej_pkg::KEY_W-1:0]              probe_ff, probe_in;
   logic                                    pend_valid_ff, pend_valid_in;
   logic [nlej_pkg::IDX_W-1:0]              pend_idx_ff, pend_idx_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [nlej_pkg::RSP_DATA_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                                    rsp_last_ff, rsp_last_in;

   logic                                    req_accept;
   nlej_pkg::op_type                        op;
   logic                                    out_free;
   logic                                    hit;
   logic                                    stall;
   logic                                    push;
   logic                                    push_last;

   assign req_tready = (state_ff == nlej_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign op         = nlej_pkg::op_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign hit        = (state_ff == nlej_pkg::ST_SCAN)
                       && (nlej_pkg::COUNT_W'(step_ff) < count_ff)
                       && (head_key == probe_ff);
   assign stall      = hit && pend_valid_ff && !out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nlej_pkg::ST_IDLE: begin
            if (req_accept && op == nlej_pkg::OP_PROBE) begin
               state_in = nlej_pkg::ST_SCAN;
            end
         end
         nlej_pkg::ST_SCAN: begin
            if (!stall && step_ff == nlej_pkg::LAST_STEP) begin
               state_in = nlej_pkg::ST_FINISH;
            end
         end
         nlej_pkg::ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = nlej_pkg::ST_IDLE;
            end
         end
         default: state_in = nlej_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      right_in      = right_ff;
      step_in       = step_ff;
      probe_in      = probe_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      cell_ctl      = '0;
      push          = 1'b0;
      push_last     = 1'b0;

      unique case (state_ff)
         nlej_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (op)
                  nlej_pkg::OP_LOAD: begin
                     if (count_ff < nlej_pkg::FULL_COUNT) begin
                        cell_ctl.load     = 1'b1;
                        cell_ctl.load_sel = count_ff[nlej_pkg::IDX_W-1:0];
                        count_in          = count_ff + 1'b1;
                     end
                  end
                  nlej_pkg::OP_PROBE: begin
                     probe_in      = req_tdata;
                     step_in       = '0;
                     pend_valid_in = 1'b0;
                  end
                  nlej_pkg::OP_CLEAR: begin
                     count_in = '0;
                     right_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         nlej_pkg::ST_SCAN: begin
            if (!stall) begin
               cell_ctl.shift = 1'b1;
               step_in = (step_ff == nlej_pkg::LAST_STEP) ? '0 : step_ff + 1'b1;
               if (hit) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_idx_in   = step_ff;
               end
            end
         end
         nlej_pkg::ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               push          = pend_valid_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               if (right_ff != nlej_pkg::RIGHT_MAX) begin
                  right_in = right_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{nlej_pkg::RSP_PAD_W{1'b0}}, probe_ff, right_ff,
                         nlej_pkg::LEFT_INDEX_W'(pend_idx_ff)};
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nlej_pkg::ST_IDLE;
         count_ff      <= '0;
         right_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         right_ff      <= right_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      probe_ff    <= probe_in;
      pend_idx_ff <= pend_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/nested_loop_equi_join.sv =====
// ----------------------------------------------------------------------------
// nested_loop_equi_join: equi-join of a stored left key column
// Left keys sit in a ring of cells; a probe rotates the ring once past one
// comparator at the head cell and reports each match in left-row order.
// ----------------------------------------------------------------------------
// A probe holds off the next request until it has finished: the ring turns
// one cell per cycle, unless stalled, for a full revolution past the single
// head comparator, then the finish state settles the final match. The ring
// stalls while a match is found with an earlier match held back and the
// result register still held by the consumer, and the finish state waits
// until the final match can enter the result register. Probes with no match
// give no result but still advance the right-row counter, which saturates at
// 65535.
module nested_loop_equi_join (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nlej_pkg::KEY_W-1:0]        req_tdata,  // [31:0] key
   input  logic [nlej_pkg::OP_W-1:0]         req_tuser,  // [1:0] operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [5:0] left_index, [21:6] right_index, [53:22] match_key, [55:54] zero
   output logic [nlej_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast   // last
);

   nlej_pkg::cell_ctl_type     cell_ctl;
   logic [nlej_pkg::KEY_W-1:0] ring_key [nlej_pkg::LEFT_ROWS];

   nlej_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_key   (ring_key[0]),
      .cell_ctl   (cell_ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   for (genvar i = 0; i < nlej_pkg::LEFT_ROWS; i++) begin : g_cell
      nlej_cell u_cell (
         .clock        (clock),
         .load_en      (cell_ctl.load && cell_ctl.load_sel == nlej_pkg::IDX_W'(i)),
         .shift_en     (cell_ctl.shift),
         .load_key     (req_tdata),
         .neighbor_key (ring_key[(i + 1) % nlej_pkg::LEFT_ROWS]),
         .cell_key     (ring_key[i])
      );
   end

endmodule

// ===== hw/rtl/nlej_checker.sv =====
// ----------------------------------------------------------------------------
// nlej_checker: port-level checks for the nested-loop equi-join
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module nlej_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [nlej_pkg::OP_W-1:0]         req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [nlej_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_busy_mid_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken before probe finished");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_no_result_load_clear: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != nlej_pkg::OP_PROBE && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result from non-probe transfer");

endmodule

bind nested_loop_equi_join nlej_checker u_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for nested_loop_equi_join
// Loads left keys, probes them with right keys and clears the store, with
// random gaps and stalls on both streams. Every accepted request updates a
// model of the key store and row counters. Every match transfer is checked
// field by field against the oldest pending match.
// ----------------------------------------------------------------------------
module tb;
   import nlej_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 420;
   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int RI_LO = LEFT_INDEX_W;
   localparam int MK_LO = LEFT_INDEX_W + RIGHT_INDEX_W;

   typedef struct {
      logic [LEFT_INDEX_W-1:0]  left_index;
      logic [RIGHT_INDEX_W-1:0] right_index;
      logic [KEY_W-1:0]         match_key;
      logic                     last;
   } join_match_type;

   class join_match_board;
      logic [KEY_W-1:0]         left_keys [LEFT_ROWS];
      int                       left_count;
      logic [RIGHT_INDEX_W-1:0] right_count;
      join_match_type           pending_matches [$];
      int                       errors;

      function new();
         left_count  = 0;
         right_count = '0;
         errors      = 0;
      endfunction

      function int pending();
         return pending_matches.size();
      endfunction

      function void take_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
         int hits;
         int seen;
         join_match_type m;
         hits = 0;
         seen = 0;
         case (op)
            OP_LOAD: begin
               if (left_count < LEFT_ROWS) begin
                  left_keys[left_count] = key;
                  left_count++;
               end
            end
            OP_CLEAR: begin
               left_count  = 0;
               right_count = '0;
            end
            OP_PROBE: begin
               for (int i = 0; i < left_count; i++)
                  if (left_keys[i] == key) hits++;
               for (int i = 0; i < left_count; i++) begin
                  if (left_keys[i] == key) begin
                     seen++;
                     m.left_index  = LEFT_INDEX_W'(i);
                     m.right_index = right_count;
                     m.match_key   = key;
                     m.last        = (seen == hits);
                     pending_matches = {pending_matches, m};
                  end
               end
               if (right_count != RIGHT_MAX) right_count++;
            end
            default: ;
         endcase
      endfunction

      function void check_match(logic [RSP_DATA_W-1:0] data, logic last);
         join_match_type want;
         if (pending_matches.size() == 0) begin
            $error("match transfer with none pending: data %h last %b", data, last);
            errors++;
            return;
         end
         want = pending_matches.pop_front();
         if (data[LEFT_INDEX_W-1:0] !== want.left_index) begin
            $error("left_index expected %0d got %0d", want.left_index,
                   data[LEFT_INDEX_W-1:0]);
            errors++;
         end
         if (data[RI_LO +: RIGHT_INDEX_W] !== want.right_index) begin
            $error("right_index expected %0d got %0d", want.right_index,
                   data[RI_LO +: RIGHT_INDEX_W]);
            errors++;
         end
         if (data[MK_LO +: KEY_W] !== want.match_key) begin
            $error("match_key expected %0d got %0d", $signed(want.match_key),
                   $signed(data[MK_LO +: KEY_W]));
            errors++;
         end
         if (data[RSP_DATA_W-1:RSP_FIELDS_W] !== '0) begin
            $error("pad expected 0 got %b", data[RSP_DATA_W-1:RSP_FIELDS_W]);
            errors++;
         end
         if (last !== want.last) begin
            $error("last expected %b got %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [KEY_W-1:0]      req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   join_match_board board = new();
   logic steady = 1'b0;
   int   items_sent = 0;
   int   cycle_count = 0;

   nested_loop_equi_join DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_request(op, key);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // optionally clear, load a small key pool with repeats, then probe hits and misses
   task automatic run_session(input int s);
      logic [KEY_W-1:0] pool [8];
      int pool_n;
      int loads;
      int probes;
      logic big;
      steady = ($urandom_range(0, 4) == 0);
      big    = (s % 10 == 3);
      pool_n = big ? $urandom_range(1, 2) : $urandom_range(1, 6);
      for (int i = 0; i < pool_n; i++) pool[i] = pick_key();
      if (big || s % 4 != 1) send_request(OP_CLEAR, $urandom);
      loads = big ? $urandom_range(64, 70) : $urandom_range(1, 12);
      for (int i = 0; i < loads; i++) begin
         if ($urandom_range(0, 19) == 0) send_request(OP_UNUSED, $urandom);
         send_request(OP_LOAD, pool[$urandom_range(0, pool_n - 1)]);
      end
      probes = $urandom_range(2, 8);
      for (int i = 0; i < probes; i++) begin
         if ($urandom_range(0, 5) == 0)
            send_request(OP_LOAD, pool[$urandom_range(0, pool_n - 1)]);
         if ($urandom_range(0, 3) == 0)
            send_request(OP_PROBE, $urandom);
         else
            send_request(OP_PROBE, pool[$urandom_range(0, pool_n - 1)]);
      end
   endtask

   initial begin
      int ready_run;
      rsp_tready = 1'b0;
      ready_run  = 0;
      forever begin
         @(negedge clock);
         if (ready_run == 0) begin
            if (steady) begin
               rsp_tready = 1'b1;
               ready_run  = 1;
            end else if (rsp_tready) begin
               rsp_tready = 1'b0;
               ready_run  = pick_stall();
            end else begin
               rsp_tready = 1'b1;
               ready_run  = $urandom_range(1, 16);
            end
         end
         ready_run--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_match(rsp_tdata, rsp_tlast);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      int s;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_LOAD;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty store, ignored opcode, extreme keys, duplicate keys, misses
      send_request(OP_PROBE, 32'd5);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
      send_request(OP_LOAD, 32'h8000_0000);
      send_request(OP_LOAD, 32'h7FFF_FFFF);
      send_request(OP_LOAD, 32'h0000_0000);
      send_request(OP_LOAD, 32'hFFFF_FFFF);
      send_request(OP_LOAD, 32'h8000_0000);
      send_request(OP_PROBE, 32'h8000_0000);
      send_request(OP_PROBE, 32'h7FFF_FFFF);
      send_request(OP_PROBE, 32'h0000_0000);
      send_request(OP_PROBE, 32'hFFFF_FFFF);
      send_request(OP_PROBE, 32'h1234_5678);
      send_request(OP_UNUSED, 32'h0000_0000);
      send_request(OP_CLEAR, 32'h0000_0000);
      send_request(OP_PROBE, 32'h0000_0000);
      send_request(OP_LOAD, 32'hA5A5_A5A5);
      send_request(OP_PROBE, 32'hA5A5_A5A5);
      send_request(OP_CLEAR, 32'h5A5A_5A5A);
      hold_until_drained();

      s = 0;
      while (items_sent < ITEM_TARGET) begin
         run_session(s);
         if (s % 7 == 5) hold_until_drained();
         s++;
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (LEFT_ROWS + 8) @(posedge clock);
      if (board.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule

// ===== nested_loop_equi_join.f =====
hw/rtl/nlej_pkg.sv
hw/rtl/nlej_cell.sv
hw/rtl/nlej_ctrl.sv
hw/rtl/nested_loop_equi_join.sv
hw/rtl/nlej_checker.sv
bench/tb.sv
